// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; they compile to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FQP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define FQP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FQP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FQP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/fqp_pkg.sv -----
// ---------------------------------------------------------------------------
// fqp_pkg
// Shared constants and types of the four-lane float quantizer and packer.
// ---------------------------------------------------------------------------
`default_nettype none

package fqp_pkg;

    localparam int FLOAT_WIDTH        = 32;
    localparam int MAX_LANES          = 4;
    localparam int IN_WIDTH           = FLOAT_WIDTH * MAX_LANES;
    localparam int OUT_WIDTH          = 64;
    localparam int DEFAULT_LANE_WIDTH = 16;
    localparam int DEFAULT_LANES      = 4;

    localparam int INT_BITS_WIDTH  = 4;
    localparam int FRAC_BITS_WIDTH = 5;
    localparam int CFG_DATA_WIDTH  = 5;

    localparam logic [INT_BITS_WIDTH-1:0]  INT_BITS_RESET  = 4'd5;
    localparam logic [FRAC_BITS_WIDTH-1:0] FRAC_BITS_RESET = 5'd11;

    // Register indexes of the configuration port.
    localparam logic REG_INT_BITS  = 1'b0;
    localparam logic REG_FRAC_BITS = 1'b1;

    // Exponent bias plus the 23 fraction bits of the significand.
    localparam logic [9:0] SHIFT_BIAS = 10'd150;

    typedef struct packed {
        logic [INT_BITS_WIDTH-1:0]  int_bits;
        logic [FRAC_BITS_WIDTH-1:0] frac_bits;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fqp_lane.sv -----
// ---------------------------------------------------------------------------
// fqp_lane
// One quantizer lane: float decode and shift into a registered magnitude,
// then saturation, negation and truncation to the lane width.
// ---------------------------------------------------------------------------
`default_nettype none

module fqp_lane
    import fqp_pkg::*;
#(
    parameter int LANE_WIDTH = DEFAULT_LANE_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   load,
    input  wire logic [FLOAT_WIDTH-1:0] value,
    input  wire cfg_t                   cfg,
    output logic      [LANE_WIDTH-1:0]  lane_q
);

    // Stage one: decode and align.
    logic        neg;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [7:0]  e_eff;
    logic [9:0]  sh;
    logic [9:0]  rsh;
    logic [55:0] wide;
    logic [23:0] quot;
    logic [23:0] keep_mask;
    logic        lost;

    logic [31:0] mag_next;
    logic        big_next;

    logic [31:0] mag_reg;
    logic        big_reg;
    logic        neg_reg;

    always_comb
    begin
        neg       = value[31];
        expo      = value[30:23];
        mant      = {(expo != 8'd0), value[22:0]};
        e_eff     = (expo == 8'd0) ? 8'd1 : expo;
        sh        = {2'b00, e_eff} + {5'b00000, cfg.frac_bits} - SHIFT_BIAS;
        rsh       = 10'd0 - sh;
        wide      = {32'd0, mant} << sh[4:0];
        quot      = mant >> rsh[4:0];
        keep_mask = ~({24{1'b1}} << rsh[4:0]);
        lost      = |(mant & keep_mask);
        mag_next  = '0;
        big_next  = 1'b0;
        if (expo == 8'hFF)
        begin
            big_next = 1'b1;
        end
        else if (!sh[9] && (sh[8:5] != 4'd0))
        begin
            // Shifted by 32 or more: nothing lands in the low word.
            big_next = (mant != 24'd0);
        end
        else if (!sh[9])
        begin
            mag_next = wide[31:0];
            big_next = |wide[55:32];
        end
        else if (rsh >= 10'd24)
        begin
            mag_next = {31'd0, neg && (mant != 24'd0)};
        end
        else
        begin
            mag_next = {8'd0, quot} + {31'd0, neg && lost};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= mag_next;
            big_reg <= big_next;
            neg_reg <= neg;
        end
    end

    // Stage two: saturate, negate, truncate.
    logic [5:0]  sum_bits;
    logic [4:0]  lim_pos;
    logic        sat;
    logic [31:0] fmask;
    logic [31:0] limit;
    logic [31:0] sat_val;
    logic [31:0] val;
    logic [31:0] res;

    always_comb
    begin
        sum_bits = {2'b00, cfg.int_bits} + {1'b0, cfg.frac_bits};
        lim_pos  = (sum_bits > 6'd31) ? 5'd31 : sum_bits[4:0];
        sat      = big_reg || ((mag_reg >> lim_pos) != 32'd0);
        fmask    = ~(32'hFFFF_FFFF << cfg.frac_bits);
        limit    = (32'd1 << cfg.int_bits) - 32'd1;
        sat_val  = (mag_reg & fmask) | (limit << cfg.frac_bits);
        val      = sat ? sat_val : mag_reg;
        res      = neg_reg ? (32'd0 - val) : val;
        lane_q   = res[LANE_WIDTH-1:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fqp_pack.sv -----
// ---------------------------------------------------------------------------
// fqp_pack
// Merges the lane results into one zero-filled output word and holds it.
// ---------------------------------------------------------------------------
`default_nettype none

module fqp_pack
    import fqp_pkg::*;
#(
    parameter int LANE_WIDTH = DEFAULT_LANE_WIDTH,
    parameter int LANES      = DEFAULT_LANES
)
(
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic [LANES*LANE_WIDTH-1:0] lanes,
    output logic      [OUT_WIDTH-1:0]        word_reg
);

    logic [OUT_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = '0;
        word_next[LANES*LANE_WIDTH-1:0] = lanes;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/float_quantize_pack4.sv -----
// ---------------------------------------------------------------------------
// float_quantize_pack4
// Four-lane single-precision to fixed-point quantizer with word packing.
// ---------------------------------------------------------------------------
// Input words arrive on the s_axis channel, each carrying four IEEE single
// precision bit patterns; every accepted word yields exactly one 64-bit word
// on the m_axis channel, in order. Each lane holds int_bits integer bits and
// frac_bits fraction bits, truncated towards minus infinity in magnitude
// terms as floor for positives and ceiling of the magnitude for negatives,
// saturated on the integer part and then negated for negative inputs.
// From acceptance to m_axis_tvalid a word passes the register stage after
// the decode and alignment shifter in each lane and then the output
// register after the saturation and packing logic. One word is accepted per
// cycle for as long as the receiver keeps up. When the receiver stalls, the
// finished word waits in the output register while the lane stage still
// takes one more word; only then does s_axis_tready fall. Reset clears both
// valid flags and returns int_bits to 5 and frac_bits to 11. Configuration
// writes are taken at any edge with cfg_we high and should only be made
// while no word is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module float_quantize_pack4
    import fqp_pkg::*;
#(
    parameter int LANE_WIDTH = DEFAULT_LANE_WIDTH,
    parameter int LANES      = DEFAULT_LANES
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Configuration write port.
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,
    // Input stream.
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: lane0_value, lane1_value, lane2_value, lane3_value.
    input  wire logic [IN_WIDTH-1:0]       s_axis_tdata,
    // Output stream.
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // Fields from bit 0: packed_word.
    output logic      [OUT_WIDTH-1:0]      m_axis_tdata
);

    // Configuration registers.
    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_INT_BITS:  cfg_next.int_bits  = cfg_data[INT_BITS_WIDTH-1:0];
                REG_FRAC_BITS: cfg_next.frac_bits = cfg_data[FRAC_BITS_WIDTH-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.int_bits  <= INT_BITS_RESET;
            cfg_reg.frac_bits <= FRAC_BITS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline control. Each stage moves when it is empty or the stage after
    // it is moving, so a bubble is squeezed out even while the output stalls.
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic s2_ready;
    logic s1_load;
    logic out_load;

    always_comb
    begin
        s2_ready       = !out_valid_reg || m_axis_tready;
        s_axis_tready  = !s1_valid_reg || s2_ready;
        s1_load        = s_axis_tvalid && s_axis_tready;
        out_load       = s1_valid_reg && s2_ready;
        s1_valid_next  = s1_load || (s1_valid_reg && !s2_ready);
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Lanes: one quantizer per float in the input word.
    logic [LANES*LANE_WIDTH-1:0] lane_bus;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        fqp_lane #(
            .LANE_WIDTH (LANE_WIDTH)
        ) u_lane (
            .clk    (clk),
            .load   (s1_load),
            .value  (s_axis_tdata[FLOAT_WIDTH*g +: FLOAT_WIDTH]),
            .cfg    (cfg_reg),
            .lane_q (lane_bus[LANE_WIDTH*g +: LANE_WIDTH])
        );
    end

    // Merge and output register.
    fqp_pack #(
        .LANE_WIDTH (LANE_WIDTH),
        .LANES      (LANES)
    ) u_pack (
        .clk      (clk),
        .load     (out_load),
        .lanes    (lane_bus),
        .word_reg (m_axis_tdata)
    );

    assign m_axis_tvalid = out_valid_reg;

    // A lane stage that cannot hand on its word keeps it.
    `FQP_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s2_ready, s1_valid_reg)
    // An accepted input word always lands in the lane stage.
    `FQP_ASSERT_NXT(a_s1_fill, clk, rst_n, s_axis_tvalid && s_axis_tready, s1_valid_reg)
    // A word handed on from the lanes shows up on the output.
    `FQP_ASSERT_NXT(a_out_fill, clk, rst_n, s1_valid_reg && s2_ready, m_axis_tvalid)
    // Bits above the packed lanes are always zero.
    `FQP_ASSERT_IMP(a_zero_fill, clk, rst_n, m_axis_tvalid,
                    (m_axis_tdata >> (LANES*LANE_WIDTH)) == '0)

endmodule

`default_nettype wire
